/* src/bkvt_pkg.sv */
// Shared types, byte codes and key name tables for the record tokenizer.
package bkvt_pkg;

  typedef enum logic [2:0] {
    PH_ENTRY = 3'd0,
    PH_WAIT  = 3'd1,
    PH_KEY   = 3'd2,
    PH_VALUE = 3'd3,
    PH_END   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_STR  = 3'd0,
    K_BOOL = 3'd1,
    K_LIST = 3'd2,
    K_DATE = 3'd3,
    K_ID   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    LP_WAIT  = 2'd0,
    LP_INDEX = 2'd1,
    LP_ITEM  = 2'd2
  } lphase_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_KEYBYTE   = 4'd1,
    EV_KEYCLEAR  = 4'd2,
    EV_KEYDONE   = 4'd3,
    EV_STRBYTE   = 4'd4,
    EV_STRDONE   = 4'd5,
    EV_TRUE      = 4'd6,
    EV_FALSE     = 4'd7,
    EV_BOOLUNSET = 4'd8,
    EV_DATE      = 4'd9,
    EV_ID        = 4'd10,
    EV_ITEMBYTE  = 4'd11,
    EV_ITEMDONE  = 4'd12,
    EV_ENTRYDONE = 4'd13
  } event_t;

  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_STR     = 8'h01;
  localparam logic [7:0] BYTE_BOOL    = 8'h02;
  localparam logic [7:0] BYTE_TRAILER = 8'h08;

  localparam logic [3:0] DATE_KEY_LEN = 4'd12;
  localparam logic [3:0] ID_KEY_LEN   = 4'd5;
  localparam logic [3:0] KEY_POS_MAX  = 4'd15;

  localparam logic [1:0] MATCH_ALL = 2'b11;
  localparam logic [1:0] ID_LAST   = 2'd3;
  localparam logic [1:0] END_LAST  = 2'd2;

  typedef struct packed {
    phase_t      phase;
    kind_t       kind;
    lphase_t     lphase;
    logic [1:0]  trailer_cnt;
    logic [1:0]  id_cnt;
    logic [23:0] id_low;
    logic [3:0]  key_pos;
    logic [1:0]  key_match;  // bit 0: date key prefix, bit 1: id key prefix
  } state_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    kind_t       kind;
    logic [31:0] idv;
  } res_t;

  // "lastplaytime", one character per key position
  function automatic logic [7:0] date_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h6c;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h73;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h70;
      4'd5:    c = 8'h6c;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h79;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h69;
      4'd10:   c = 8'h6d;
      4'd11:   c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "appid"
  function automatic logic [7:0] id_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h61;
      4'd1:    c = 8'h70;
      4'd2:    c = 8'h70;
      4'd3:    c = 8'h69;
      4'd4:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* src/bkvt_step.sv */
// Next-state and event logic for one byte of the record stream.
module bkvt_step (
  input  bkvt_pkg::state_t st,
  input  logic [7:0]       byte_in,
  output bkvt_pkg::state_t st_nxt,
  output bkvt_pkg::res_t   res
);

  bkvt_pkg::event_t ev;
  logic [7:0]       data;
  logic [31:0]      idv;

  always_comb begin
    st_nxt = st;
    ev     = bkvt_pkg::EV_NONE;
    data   = 8'd0;
    idv    = 32'd0;
    case (st.phase)
      bkvt_pkg::PH_ENTRY: begin
        if (byte_in == bkvt_pkg::BYTE_BOOL) begin
          st_nxt.phase = bkvt_pkg::PH_KEY;
          st_nxt.kind  = bkvt_pkg::K_BOOL;
        end else if (byte_in == bkvt_pkg::BYTE_STR) begin
          st_nxt.phase = bkvt_pkg::PH_KEY;
          st_nxt.kind  = bkvt_pkg::K_STR;
        end
      end
      bkvt_pkg::PH_WAIT: begin
        if (byte_in != bkvt_pkg::BYTE_TRAILER) begin
          st_nxt.phase = bkvt_pkg::PH_KEY;
          if (byte_in == bkvt_pkg::BYTE_STR) begin
            st_nxt.kind = bkvt_pkg::K_STR;
          end else if (byte_in == bkvt_pkg::BYTE_BOOL) begin
            st_nxt.kind = bkvt_pkg::K_BOOL;
          end else if (byte_in == bkvt_pkg::BYTE_NUL) begin
            st_nxt.kind = bkvt_pkg::K_LIST;
          end
        end
      end
      bkvt_pkg::PH_KEY: begin
        if (byte_in == bkvt_pkg::BYTE_STR) begin
          st_nxt.key_pos   = 4'd0;
          st_nxt.key_match = bkvt_pkg::MATCH_ALL;
          ev               = bkvt_pkg::EV_KEYCLEAR;
        end else if (byte_in != bkvt_pkg::BYTE_NUL) begin
          if (st.key_pos >= bkvt_pkg::DATE_KEY_LEN ||
              bkvt_pkg::date_char(st.key_pos) != byte_in) begin
            st_nxt.key_match[0] = 1'b0;
          end
          if (st.key_pos >= bkvt_pkg::ID_KEY_LEN ||
              bkvt_pkg::id_char(st.key_pos) != byte_in) begin
            st_nxt.key_match[1] = 1'b0;
          end
          if (st.key_pos < bkvt_pkg::KEY_POS_MAX) begin
            st_nxt.key_pos = st.key_pos + 4'd1;
          end
          ev   = bkvt_pkg::EV_KEYBYTE;
          data = byte_in;
        end else begin
          if (st.key_pos == bkvt_pkg::DATE_KEY_LEN && st.key_match[0]) begin
            st_nxt.kind = bkvt_pkg::K_DATE;
          end
          if (st.key_pos == bkvt_pkg::ID_KEY_LEN && st.key_match[1]) begin
            st_nxt.kind = bkvt_pkg::K_ID;
          end
          st_nxt.key_pos   = 4'd0;
          st_nxt.key_match = bkvt_pkg::MATCH_ALL;
          st_nxt.phase     = bkvt_pkg::PH_VALUE;
          ev               = bkvt_pkg::EV_KEYDONE;
        end
      end
      bkvt_pkg::PH_VALUE: begin
        case (st.kind)
          bkvt_pkg::K_STR: begin
            if (byte_in != bkvt_pkg::BYTE_NUL) begin
              ev   = bkvt_pkg::EV_STRBYTE;
              data = byte_in;
            end else begin
              ev           = bkvt_pkg::EV_STRDONE;
              st_nxt.phase = bkvt_pkg::PH_WAIT;
            end
          end
          bkvt_pkg::K_BOOL: begin
            if (byte_in == bkvt_pkg::BYTE_STR) begin
              ev = bkvt_pkg::EV_TRUE;
            end else if (byte_in == bkvt_pkg::BYTE_NUL) begin
              ev = bkvt_pkg::EV_FALSE;
            end else begin
              ev = bkvt_pkg::EV_BOOLUNSET;
            end
            st_nxt.phase = bkvt_pkg::PH_END;
          end
          bkvt_pkg::K_DATE: begin
            ev           = bkvt_pkg::EV_DATE;
            st_nxt.phase = bkvt_pkg::PH_END;
          end
          bkvt_pkg::K_ID: begin
            if (st.id_cnt != bkvt_pkg::ID_LAST) begin
              // little-endian: byte lands at lane id_cnt
              st_nxt.id_low = st.id_low | ({16'd0, byte_in} << {st.id_cnt, 3'b000});
              st_nxt.id_cnt = st.id_cnt + 2'd1;
            end else begin
              idv           = {byte_in, st.id_low};
              ev            = bkvt_pkg::EV_ID;
              st_nxt.id_cnt = 2'd0;
              st_nxt.id_low = 24'd0;
              st_nxt.phase  = bkvt_pkg::PH_WAIT;
            end
          end
          bkvt_pkg::K_LIST: begin
            case (st.lphase)
              bkvt_pkg::LP_WAIT: begin
                if (byte_in == bkvt_pkg::BYTE_TRAILER) begin
                  if (st.trailer_cnt == 2'd0) begin
                    st_nxt.trailer_cnt = 2'd1;
                  end else begin
                    st_nxt.trailer_cnt = 2'd0;
                    st_nxt.phase       = bkvt_pkg::PH_ENTRY;
                    ev                 = bkvt_pkg::EV_ENTRYDONE;
                  end
                end else begin
                  st_nxt.lphase = bkvt_pkg::LP_INDEX;
                end
              end
              bkvt_pkg::LP_INDEX: begin
                if (byte_in == bkvt_pkg::BYTE_NUL) begin
                  st_nxt.lphase = bkvt_pkg::LP_ITEM;
                end
              end
              bkvt_pkg::LP_ITEM: begin
                if (byte_in != bkvt_pkg::BYTE_NUL) begin
                  ev   = bkvt_pkg::EV_ITEMBYTE;
                  data = byte_in;
                end else begin
                  ev            = bkvt_pkg::EV_ITEMDONE;
                  st_nxt.lphase = bkvt_pkg::LP_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      bkvt_pkg::PH_END: begin
        // trailing bytes after a boolean or date value
        if (st.kind == bkvt_pkg::K_BOOL || st.kind == bkvt_pkg::K_DATE) begin
          if (st.trailer_cnt < bkvt_pkg::END_LAST) begin
            st_nxt.trailer_cnt = st.trailer_cnt + 2'd1;
          end else if (st.trailer_cnt == bkvt_pkg::END_LAST) begin
            st_nxt.trailer_cnt = 2'd0;
            st_nxt.phase       = bkvt_pkg::PH_WAIT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.ev   = ev;
    res.data = data;
    res.kind = st_nxt.kind;
    res.idv  = idv;
  end

endmodule

/* src/binary_keyvalue_record_tokenizer_top.sv */
// Top level: byte input register, tokenizer step logic and event output register.
// A byte passes the input register, then its event the output register.
// Throughput: one byte per cycle unless stalled; one event transaction per byte.
// The parse state updates in the same edge that loads the output register.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the entry-type phase with string type.
module binary_keyvalue_record_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_value_kind,
  output logic [31:0] out_id_value
);

  logic             byte_vld_r;
  logic [7:0]       byte_r;
  logic             out_vld_r;
  bkvt_pkg::res_t   res_r;
  bkvt_pkg::res_t   res_nxt;
  bkvt_pkg::state_t st_r;
  bkvt_pkg::state_t st_nxt;
  logic             out_free;
  logic             advance;

  bkvt_step u_step (
    .st      (st_r),
    .byte_in (byte_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = byte_vld_r && out_free;
  assign in_stall = byte_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (!in_stall) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= byte_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= bkvt_pkg::PH_ENTRY;
      st_r.kind        <= bkvt_pkg::K_STR;
      st_r.lphase      <= bkvt_pkg::LP_WAIT;
      st_r.trailer_cnt <= 2'd0;
      st_r.id_cnt      <= 2'd0;
      st_r.id_low      <= 24'd0;
      st_r.key_pos     <= 4'd0;
      st_r.key_match   <= bkvt_pkg::MATCH_ALL;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_res  = res_r.ev;
  assign out_data_byte  = res_r.data;
  assign out_value_kind = res_r.kind;
  assign out_id_value   = res_r.idv;

endmodule
